[hw/rtl/vtv_pkg.sv]
// Package for the vertex transform and viewport unit.
// Holds the fixed widths, register indexes and the word types shared by the front,
// divider and back modules. No dependencies.
package vtv_pkg;

	localparam int CoordW   = 32;
	localparam int CoefW    = 16;
	localparam int RowW     = 64;
	localparam int ScrW     = 14;
	localparam int ProdW    = CoordW + CoefW;   // 48
	localparam int AccW     = ProdW + 2;        // 50, sum of four products
	localparam int MagW     = AccW;             // magnitude of an accumulator
	localparam int QuoW     = 33;               // quotient bits kept (sat detect)
	localparam int FracW    = 16;               // fraction bits of Q16.16
	localparam int DivSteps = 32;               // 16 integer bits + 16 fraction bits
	localparam int CfgIdxW  = 3;

	localparam logic [CfgIdxW-1:0] RegRow0  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegRow1  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegRow2  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegRow3  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegWidth = 3'd4;
	localparam logic [CfgIdxW-1:0] RegHeight = 3'd5;
	localparam logic [CfgIdxW-1:0] RegVpEn  = 3'd6;

	localparam logic signed [CoordW-1:0] QMax = 32'sh7FFF_FFFF;
	localparam logic signed [CoordW-1:0] QMin = 32'sh8000_0000;

	// Word handed from the front to the divider pipeline through the queue.
	typedef struct packed {
		logic signed [AccW-1:0] acc_x;
		logic signed [AccW-1:0] acc_y;
		logic signed [AccW-1:0] acc_z;
		logic signed [AccW-1:0] acc_w;
		logic                   last;
	} xform_word_t;

	// Word leaving the divider toward the viewport stage.
	typedef struct packed {
		logic signed [CoordW-1:0] ndc_x;
		logic signed [CoordW-1:0] ndc_y;
		logic signed [CoordW-1:0] ndc_z;
		logic                     w_zero;
		logic                     last;
	} ndc_word_t;

	// Result word placed in the output queue.
	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic                     w_zero;
		logic                     last;
	} result_word_t;

	// Saturate a 48-bit signed value into Q16.16 range.
	function automatic logic signed [CoordW-1:0] sat32(input logic signed [ProdW-1:0] v);
		logic signed [CoordW-1:0] r;
		if (v > ProdW'(QMax))
			r = QMax;
		else if (v < ProdW'(QMin))
			r = QMin;
		else
			r = v[CoordW-1:0];
		return r;
	endfunction

endpackage

[hw/rtl/vtv_fifo.sv]
// Small register queue used between the front, back and the output side.
// No dependencies; width and depth are fixed per use.
module vtv_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);
	localparam int PtrW = $clog2(Depth);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [PtrW:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (PtrW+1)'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Store incoming words
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
		end
	end
endmodule

[hw/rtl/vtv_front.sv]
// Front part: matrix multiply of one vertex in two stages (products, then sums).
// Depends on vtv_pkg.
module vtv_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                in_valid,
	input  logic [vtv_pkg::RowW-1:0]            row [4],
	input  logic signed [vtv_pkg::CoordW-1:0]   in_x,
	input  logic signed [vtv_pkg::CoordW-1:0]   in_y,
	input  logic signed [vtv_pkg::CoordW-1:0]   in_z,
	input  logic signed [vtv_pkg::CoordW-1:0]   in_w,
	input  logic                                last_in,
	output logic                                out_valid,
	output vtv_pkg::xform_word_t                out_word
);
	import vtv_pkg::*;

	logic signed [ProdW-1:0]  prod_s1 [4][4];
	logic                     last_s1, vld_s1;
	xform_word_t              word_s2;
	logic                     vld_s2;
	logic signed [CoordW-1:0] vin [4];
	logic signed [AccW-1:0]   sum [4];

	assign vin[0] = in_x;
	assign vin[1] = in_y;
	assign vin[2] = in_z;
	assign vin[3] = in_w;

	// Stage 1: sixteen coefficient products
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 4; r++)
				for (int j = 0; j < 4; j++)
					prod_s1[r][j] <= $signed(row[r][16*j +: CoefW]) * vin[j];
			last_s1 <= last_in;
		end
	end

	// Stage 2: add each row
	always_comb begin
		for (int r = 0; r < 4; r++)
			sum[r] = AccW'(prod_s1[r][0]) + AccW'(prod_s1[r][1])
			       + AccW'(prod_s1[r][2]) + AccW'(prod_s1[r][3]);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2.acc_x <= sum[0];
			word_s2.acc_y <= sum[1];
			word_s2.acc_z <= sum[2];
			word_s2.acc_w <= sum[3];
			word_s2.last  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_word  = word_s2;
endmodule

[hw/rtl/vtv_div.sv]
// Pipelined restoring divider: three quotients sharing one divisor, one bit per stage.
// Depends on vtv_pkg. Produces saturated Q16.16 quotients and the zero-w flag.
module vtv_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_valid,
	input  vtv_pkg::xform_word_t in_word,
	output logic                 out_valid,
	output vtv_pkg::ndc_word_t   out_word
);
	import vtv_pkg::*;

	localparam int RemW = MagW + 1;

	// Per-stage state of the bit-serial pipeline
	logic [DivSteps-1:0] num_q  [DivSteps+1][3];
	logic [RemW-1:0] rem_q  [DivSteps+1][3];
	logic [QuoW-1:0] quo_q  [DivSteps+1][3];
	logic            neg_q  [DivSteps+1][3];
	logic            pos_q  [DivSteps+1][3];
	logic            nz_q   [DivSteps+1][3];
	logic            big_q  [DivSteps+1][3];
	logic [MagW-1:0] den_q  [DivSteps+1];
	logic            wz_q   [DivSteps+1];
	logic            last_q [DivSteps+1];
	logic            vld_q  [DivSteps+1];

	logic signed [AccW-1:0] accs [3];
	logic [MagW-1:0]        amag [3];
	logic [MagW-1:0]        wmag;

	assign accs[0] = in_word.acc_x;
	assign accs[1] = in_word.acc_y;
	assign accs[2] = in_word.acc_z;
	assign wmag    = in_word.acc_w[AccW-1] ? MagW'(-in_word.acc_w) : MagW'(in_word.acc_w);

	always_comb begin
		for (int k = 0; k < 3; k++)
			amag[k] = accs[k][AccW-1] ? MagW'(-accs[k]) : MagW'(accs[k]);
	end

	// Entry: magnitudes, signs and the overflow check. The dividend is the
	// magnitude shifted left 16: its upper bits seed the remainder and its low
	// 32 bits are shifted in one per step. The integer quotient reaches 65536
	// exactly when the magnitude is at least the divisor shifted left 16.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < 3; k++) begin
				num_q[0][k] <= {amag[k][FracW-1:0], {FracW{1'b0}}};
				rem_q[0][k] <= RemW'(amag[k][MagW-1:FracW]);
				quo_q[0][k] <= '0;
				neg_q[0][k] <= accs[k][AccW-1] ^ in_word.acc_w[AccW-1];
				pos_q[0][k] <= !accs[k][AccW-1] && (accs[k] != '0);
				nz_q[0][k]  <= (accs[k] != '0);
				big_q[0][k] <= ({{FracW{1'b0}}, amag[k]} >= {wmag, {FracW{1'b0}}});
			end
			den_q[0]  <= wmag;
			wz_q[0]   <= (in_word.acc_w == '0);
			last_q[0] <= in_word.last;
		end
	end

	// One quotient bit per stage; dividend bits come from the low part of num.
	for (genvar s = 0; s < DivSteps; s++) begin : g_step
		logic [RemW-1:0] trial [3];
		logic            nbit  [3];
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				nbit[k]  = num_q[s][k][DivSteps-1];
				trial[k] = {rem_q[s][k][RemW-2:0], nbit[k]};
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				for (int k = 0; k < 3; k++) begin
					num_q[s+1][k] <= {num_q[s][k][DivSteps-2:0], 1'b0};
					if (trial[k] >= RemW'(den_q[s])) begin
						rem_q[s+1][k] <= trial[k] - RemW'(den_q[s]);
						quo_q[s+1][k] <= {quo_q[s][k][QuoW-2:0], 1'b1};
					end else begin
						rem_q[s+1][k] <= trial[k];
						quo_q[s+1][k] <= {quo_q[s][k][QuoW-2:0], 1'b0};
					end
					neg_q[s+1][k] <= neg_q[s][k];
					pos_q[s+1][k] <= pos_q[s][k];
					nz_q[s+1][k]  <= nz_q[s][k];
					big_q[s+1][k] <= big_q[s][k];
				end
				den_q[s+1]  <= den_q[s];
				wz_q[s+1]   <= wz_q[s];
				last_q[s+1] <= last_q[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= DivSteps; s++)
				vld_q[s] <= 1'b0;
		end else if (advance) begin
			vld_q[0] <= in_valid;
			for (int s = 0; s < DivSteps; s++)
				vld_q[s+1] <= vld_q[s];
		end
	end

	// Saturate and apply the sign
	always_comb begin
		logic signed [CoordW-1:0] res [3];
		logic [QuoW-1:0]          mag;
		logic                     big;
		for (int k = 0; k < 3; k++) begin
			mag = quo_q[DivSteps][k];
			big = big_q[DivSteps][k];
			if (wz_q[DivSteps])
				res[k] = pos_q[DivSteps][k] ? QMax : (nz_q[DivSteps][k] ? QMin : '0);
			else if (neg_q[DivSteps][k])
				res[k] = (big || mag > QuoW'(33'h0_8000_0000)) ? QMin
				       : CoordW'(-mag);
			else
				res[k] = (big || mag > QuoW'(33'h0_7FFF_FFFF)) ? QMax
				       : CoordW'(mag);
		end
		out_word.ndc_x  = res[0];
		out_word.ndc_y  = res[1];
		out_word.ndc_z  = res[2];
		out_word.w_zero = wz_q[DivSteps];
		out_word.last   = last_q[DivSteps];
	end

	assign out_valid = vld_q[DivSteps];
endmodule

[hw/rtl/vtv_back.sv]
// Back part: perspective divide pipeline followed by viewport mapping.
// Depends on vtv_pkg and vtv_div.
module vtv_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   in_valid,
	input  vtv_pkg::xform_word_t   in_word,
	input  logic [vtv_pkg::ScrW-1:0] scr_w,
	input  logic [vtv_pkg::ScrW-1:0] scr_h,
	input  logic                   vp_en,
	output logic                   out_valid,
	output vtv_pkg::result_word_t  out_word
);
	import vtv_pkg::*;

	logic      div_valid;
	ndc_word_t ndc;

	vtv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (in_valid),
		.in_word  (in_word),
		.out_valid(div_valid),
		.out_word (ndc)
	);

	logic signed [ProdW-1:0] vx_s1, vy_s1, vz_s1;
	logic                    map_s1, vld_s1, vld_s2;
	ndc_word_t               ndc_s1;
	result_word_t            res_s2;

	// Stage 1: add one, and scale x and y by the screen width and height
	always_ff @(posedge clk) begin
		if (advance) begin
			vx_s1  <= (ProdW'(ndc.ndc_x) + ProdW'(65536)) * $signed({1'b0, scr_w});
			vy_s1  <= (ProdW'(ndc.ndc_y) + ProdW'(65536)) * $signed({1'b0, scr_h});
			vz_s1  <= ProdW'(ndc.ndc_z) + ProdW'(65536);
			map_s1 <= vp_en && !ndc.w_zero;
			ndc_s1 <= ndc;
		end
	end

	// Stage 2: halve toward minus infinity and saturate, or pass the NDC word through
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.x      <= map_s1 ? sat32(vx_s1 >>> 1) : ndc_s1.ndc_x;
			res_s2.y      <= map_s1 ? sat32(vy_s1 >>> 1) : ndc_s1.ndc_y;
			res_s2.z      <= map_s1 ? sat32(vz_s1 >>> 1) : ndc_s1.ndc_z;
			res_s2.w_zero <= ndc_s1.w_zero;
			res_s2.last   <= ndc_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= div_valid;
			vld_s2 <= vld_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_word  = res_s2;
endmodule

[hw/rtl/vertex_transform_viewport_unit.sv]
// Vertex transform and viewport unit: channels on both sides look like queues.
// Input: push a word (in_x..in_w Q16.16 and last_in) when full is low.
// Output: while empty is low the oldest result sits on out_x/out_y/out_z, w_zero
// and last_out; pop takes it.
// Configuration: cfg_we writes register cfg_idx (rows 0..3, width, height,
// viewport enable) with cfg_data; write only while the unit is idle.
// Throughput: one vertex per cycle while full is low. Empty falls after the accepting
// edge once the word has passed two matrix stages, a queue hop, the divider entry and
// its 32 bit steps, two viewport stages and the output queue.
// The front pipeline feeds a small queue; the back pipeline (divider and
// viewport) stalls whenever its last stage holds a word and the output queue
// is full, so a stalled receiver backs up into full without losing words.
// Reset clears all queues and restores the identity matrix, a 640x480 screen
// and viewport mapping on.
// Depends on vtv_pkg, vtv_front, vtv_back and vtv_fifo.
module vertex_transform_viewport_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [vtv_pkg::CoordW-1:0]  in_x,
	input  logic signed [vtv_pkg::CoordW-1:0]  in_y,
	input  logic signed [vtv_pkg::CoordW-1:0]  in_z,
	input  logic signed [vtv_pkg::CoordW-1:0]  in_w,
	input  logic                               last_in,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [vtv_pkg::CoordW-1:0]  out_x,
	output logic signed [vtv_pkg::CoordW-1:0]  out_y,
	output logic signed [vtv_pkg::CoordW-1:0]  out_z,
	output logic                               w_zero,
	output logic                               last_out,
	input  logic                               cfg_we,
	input  logic [vtv_pkg::CfgIdxW-1:0]        cfg_idx,
	input  logic [vtv_pkg::RowW-1:0]           cfg_data
);
	import vtv_pkg::*;

	localparam int OutDepth = 4;
	localparam int MidDepth = 4;
	localparam int MidCntW = $clog2(MidDepth + 1);

	logic [RowW-1:0] row_q [4];
	logic [ScrW-1:0] scr_w_q, scr_h_q;
	logic            vp_en_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'h0000_0000_0000_1000;
			row_q[1] <= 64'h0000_0000_1000_0000;
			row_q[2] <= 64'h0000_1000_0000_0000;
			row_q[3] <= 64'h1000_0000_0000_0000;
			scr_w_q  <= 14'd640;
			scr_h_q  <= 14'd480;
			vp_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegRow0:   row_q[0] <= cfg_data;
				RegRow1:   row_q[1] <= cfg_data;
				RegRow2:   row_q[2] <= cfg_data;
				RegRow3:   row_q[3] <= cfg_data;
				RegWidth:  scr_w_q  <= cfg_data[ScrW-1:0];
				RegHeight: scr_h_q  <= cfg_data[ScrW-1:0];
				RegVpEn:   vp_en_q  <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// Front: always advance; the mid queue reserves room for words in flight.
	logic        accept, f_valid;
	xform_word_t f_word;
	logic        mid_full, mid_empty, mid_pop;
	xform_word_t mid_word;
	logic [MidCntW-1:0] mid_cnt_q;

	assign accept = push && !full;

	vtv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (1'b1),
		.in_valid (accept),
		.row      (row_q),
		.in_x     (in_x),
		.in_y     (in_y),
		.in_z     (in_z),
		.in_w     (in_w),
		.last_in  (last_in),
		.out_valid(f_valid),
		.out_word (f_word)
	);

	// Count words in the front stages plus the mid queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mid_cnt_q <= '0;
		else
			mid_cnt_q <= mid_cnt_q + MidCntW'(accept) - MidCntW'(mid_pop);
	end
	assign full = (mid_cnt_q >= MidCntW'(MidDepth));

	vtv_fifo #(.Width($bits(xform_word_t)), .Depth(MidDepth)) u_mid (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_valid),
		.wdata (f_word),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_word),
		.empty (mid_empty)
	);

	// Back: hold the whole pipeline while its last word cannot enter the output queue
	logic         b_adv, b_valid, out_full, out_empty;
	result_word_t b_word, r_word;
	logic         o_pop;

	assign o_pop = pop && !out_empty;
	assign b_adv = !(b_valid && out_full);
	assign mid_pop = b_adv && !mid_empty;

	vtv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (b_adv),
		.in_valid (mid_pop),
		.in_word  (mid_word),
		.scr_w    (scr_w_q),
		.scr_h    (scr_h_q),
		.vp_en    (vp_en_q),
		.out_valid(b_valid),
		.out_word (b_word)
	);

	vtv_fifo #(.Width($bits(result_word_t)), .Depth(OutDepth)) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (b_valid && b_adv),
		.wdata (b_word),
		.full  (out_full),
		.pop   (o_pop),
		.rdata (r_word),
		.empty (out_empty)
	);

	assign empty    = out_empty;
	assign out_x    = r_word.x;
	assign out_y    = r_word.y;
	assign out_z    = r_word.z;
	assign w_zero   = r_word.w_zero;
	assign last_out = r_word.last;
endmodule

[tb/vertex_transform_viewport_unit_tb.sv]
// Testbench for vertex_transform_viewport_unit: directed table plus random vertices,
// each result checked against a literal or an in-bench predictor of transform, divide and viewport.
// Depends on vtv_pkg and the unit RTL.
module vertex_transform_viewport_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vtv_pkg::*;

	localparam int Latency  = 80;
	localparam int WdogMax  = 20000;
	localparam int StallLen = 300;
	localparam longint QHi  = 64'sd2147483647;
	localparam longint QLo  = -64'sd2147483648;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic               last;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               wz;
		logic               last;
	} screen_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
	logic last_in = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic w_zero, last_out;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [RowW-1:0] cfg_data = '0;

	vertex_transform_viewport_unit i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the configuration
	logic [63:0] mat_row [4];
	logic [13:0] scr_w, scr_h;
	logic        vp_en;

	screen_pt_t pending_pts[$];
	int errors = 0;
	int checked = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0;
	int stall_cnt = 0;
	int quiet = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_v);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, exp_v, checked);
		errors++;
	endtask

	function automatic longint div_q16(input longint num, input longint den);
		logic neg;
		longint unsigned a, b, qi, rm, fr, mag;
		neg = (num < 0) != (den < 0);
		a = num < 0 ? -num : num;
		b = den < 0 ? -den : den;
		qi = a / b;
		rm = a % b;
		fr = 0;
		if (qi >= 65536) return neg ? QLo : QHi;
		for (int i = 0; i < 16; i++) begin
			rm = rm << 1;
			fr = fr << 1;
			if (rm >= b) begin
				rm = rm - b;
				fr = fr | 1;
			end
		end
		mag = (qi << 16) | fr;
		if (neg) return mag > 64'd2147483648 ? QLo : -longint'(mag);
		return mag > 64'd2147483647 ? QHi : longint'(mag);
	endfunction

	function automatic longint to_screen(input longint ndc, input longint scale,
			input bit scaled);
		longint v, h;
		v = ndc + 65536;
		if (scaled) v = v * scale;
		h = v >= 0 ? v / 2 : -((-v + 1) / 2);
		if (h > QHi) return QHi;
		if (h < QLo) return QLo;
		return h;
	endfunction

	function automatic screen_pt_t project_vertex(input vertex_t vx);
		screen_pt_t p;
		longint acc [4];
		longint coord [4];
		longint res [3];
		logic signed [15:0] c;
		coord[0] = vx.x; coord[1] = vx.y; coord[2] = vx.z; coord[3] = vx.w;
		for (int r = 0; r < 4; r++) begin
			acc[r] = 0;
			for (int j = 0; j < 4; j++) begin
				c = mat_row[r][16*j +: 16];
				acc[r] += longint'(c) * coord[j];
			end
		end
		p.wz = (acc[3] == 0);
		for (int r = 0; r < 3; r++) begin
			if (p.wz) res[r] = acc[r] > 0 ? QHi : (acc[r] < 0 ? QLo : 0);
			else res[r] = div_q16(acc[r], acc[3]);
		end
		if (!p.wz && vp_en) begin
			res[0] = to_screen(res[0], longint'(scr_w), 1);
			res[1] = to_screen(res[1], longint'(scr_h), 1);
			res[2] = to_screen(res[2], 0, 0);
		end
		p.x = res[0][31:0]; p.y = res[1][31:0]; p.z = res[2][31:0];
		p.last = vx.last;
		return p;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= RegRow3) mat_row[idx[1:0]] = val;
		else if (idx == RegWidth) scr_w = val[13:0];
		else if (idx == RegHeight) scr_h = val[13:0];
		else if (idx == RegVpEn) vp_en = val[0];
	endtask

	// Push one vertex, optionally idling first, and queue its predicted result; the caller may replace it with a literal
	task automatic send_vertex(input vertex_t vx);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		{in_x, in_y, in_z, in_w, last_in} <= vx;
		pending_pts.push_back(project_vertex(vx));
		do @(posedge clk); while (full);
	endtask

	task automatic drain_all();
		push <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(32'h60000)) - 32'sh30000);
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 16'h8000;
			2: return 16'h7FFF;
			default: return 16'($signed($urandom_range(16'h2000)) - 16'sh1000);
		endcase
	endfunction

	// Accept results whenever the receiver is willing; check against the oldest prediction
	always @(posedge clk) begin
		screen_pt_t want;
		if (pop && !empty) begin
			if (pending_pts.size() == 0) begin
				report_mismatch("unexpected word", out_x, '0);
			end else begin
				want = pending_pts.pop_front();
				if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
				if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
				if (w_zero !== want.wz) report_mismatch("w_zero", w_zero, want.wz);
				if (last_out !== want.last) report_mismatch("last_out", last_out, want.last);
				checked++;
			end
		end
		if (hold_off && stall_cnt < StallLen) begin
			pop <= 1'b0;
			stall_cnt <= stall_cnt + 1;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog: cycles with no word moved on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WdogMax) begin
			$display("watchdog expired");
			$display("FAIL");
			$finish;
		end
	end

	typedef struct packed {
		vertex_t    vx;
		logic       typed;
		screen_pt_t pt;
	} stim_row_t;

	stim_row_t dir_rows [$];

	initial begin
		vertex_t vx;
		screen_pt_t lit;
		mat_row[0] = 64'd4096;
		mat_row[1] = 64'd268435456;
		mat_row[2] = 64'd17592186044416;
		mat_row[3] = 64'd1152921504606846976;
		scr_w = 14'd640; scr_h = 14'd480; vp_en = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; literal results where obvious (reset identity, w zero)
		dir_rows.push_back('{'{32'sh0, 32'sh0, 32'sh0, 32'sh10000, 1'b0}, 1'b1,
			'{32'sd20971520, 32'sd15728640, 32'sh8000, 1'b0, 1'b0}});
		dir_rows.push_back('{'{32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 1'b1}, 1'b1,
			'{32'sd41943040, 32'sd31457280, 32'sh10000, 1'b0, 1'b1}});
		dir_rows.push_back('{'{32'sh10000, -32'sh10000, 32'sh0, 32'sh0, 1'b0}, 1'b1,
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 1'b0}});
		dir_rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1'b1},
			1'b0, '0});
		dir_rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			1'b0}, 1'b0, '0});
		dir_rows.push_back('{'{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h7FFF_FFFF, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{'{-32'sh20000, 32'sh30000, -32'sh8000, -32'sh10000, 1'b0},
			1'b0, '0});
		dir_rows.push_back('{'{32'sh5, 32'sh3, -32'sh7, 32'sh3, 1'b1}, 1'b0, '0});
		foreach (dir_rows[i]) begin
			send_vertex(dir_rows[i].vx);
			if (dir_rows[i].typed) begin
				lit = dir_rows[i].pt;
				pending_pts[pending_pts.size()-1] = lit;
			end
		end
		drain_all();

		// Extremes of the configuration: full-scale coefficients and screen sizes
		write_reg(RegRow0, 64'h8000_7FFF_8000_7FFF);
		write_reg(RegRow1, 64'h7FFF_8000_7FFF_8000);
		write_reg(RegRow2, 64'hFFFF_0001_FFFF_0001);
		write_reg(RegRow3, 64'h0001_0000_0000_0000);
		write_reg(RegWidth, 64'd8192);
		write_reg(RegHeight, 64'd16383);
		for (int i = 0; i < 6; i++) begin
			vx.x = rand_coord(); vx.y = rand_coord(); vx.z = rand_coord();
			vx.w = rand_coord(); vx.last = i[0];
			send_vertex(vx);
		end
		drain_all();
		write_reg(RegVpEn, 64'd0);
		write_reg(RegWidth, 64'd0);
		write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 6; i++) begin
			vx.x = rand_coord(); vx.y = rand_coord(); vx.z = rand_coord();
			vx.w = rand_coord(); vx.last = i[0];
			send_vertex(vx);
		end
		drain_all();

		// Random phases: receiver slow, sender slow, then back to back
		for (int ph = 0; ph < 6; ph++) begin
			send_idle = (ph % 3 == 0) ? 35 : (ph % 3 == 1 ? 78 : 0);
			recv_idle = (ph % 3 == 0) ? 78 : (ph % 3 == 1 ? 35 : 0);
			for (int r = 0; r < 4; r++) write_reg(r[2:0], {rand_coef(), rand_coef(),
				rand_coef(), rand_coef()});
			write_reg(RegWidth, $urandom_range(3) == 0 ? 64'd16383 : 64'($urandom_range(8192)));
			write_reg(RegHeight, $urandom_range(3) == 0 ? 64'd0 : 64'($urandom_range(8192)));
			write_reg(RegVpEn, 64'(ph[0] ^ 1'b1));
			for (int i = 0; i < 200; i++) begin
				// Hold the receiver off for a long stretch to back the unit up
				if (ph == 2 && i == 20) hold_off = 1;
				vx.x = rand_coord(); vx.y = rand_coord(); vx.z = rand_coord();
				vx.w = ($urandom_range(15) == 0) ? 32'h0 : rand_coord();
				vx.last = $urandom_range(1);
				send_vertex(vx);
			end
			drain_all();
		end

		$display("checked %0d vertices over directed, extreme and random matrix settings,",
			checked);
		$display("with idling on both sides and a long receiver stall");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
